FILE: sv/oaat_pkg.sv
package oaat_pkg;

    // Field and register widths.
    localparam int unsigned HashWidth  = 32;
    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned ShiftWidth = 5;
    localparam int unsigned CfgIdxWidth  = 8;
    localparam int unsigned CfgDataWidth = 5;

    // Configuration register indexes.
    localparam logic [CfgIdxWidth-1:0] RegMixShift = 8'd0;
    localparam logic [CfgIdxWidth-1:0] RegSignExt  = 8'd1;

    // Reset values of the configuration registers.
    localparam logic [ShiftWidth-1:0] MixShiftReset = 5'd10;
    localparam logic                  SignExtReset  = 1'b1;

    // Fixed shift amounts of the mix and finalization steps.
    localparam int unsigned XorShift  = 6;
    localparam int unsigned FinShiftA = 3;
    localparam int unsigned FinShiftB = 11;
    localparam int unsigned FinShiftC = 15;

    // Mixes one byte into the running hash.
    function automatic logic [HashWidth-1:0] mix_byte(
        input logic [HashWidth-1:0]  h,
        input logic [ByteWidth-1:0]  b,
        input logic [ShiftWidth-1:0] shift,
        input logic                  sign_ext
    );
        logic [HashWidth-1:0] widened;
        logic [HashWidth-1:0] h1;
        logic [HashWidth-1:0] h2;
        begin
            if (sign_ext && b[ByteWidth-1])
            begin
                widened = {{(HashWidth-ByteWidth){1'b1}}, b};
            end
            else
            begin
                widened = {{(HashWidth-ByteWidth){1'b0}}, b};
            end
            h1 = h + widened;
            h2 = h1 + (h1 << shift);
            return h2 ^ (h2 >> XorShift);
        end
    endfunction

    // Final avalanche applied at the end of a string.
    function automatic logic [HashWidth-1:0] finalize(input logic [HashWidth-1:0] h);
        logic [HashWidth-1:0] f1;
        logic [HashWidth-1:0] f2;
        begin
            f1 = h + (h << FinShiftA);
            f2 = f1 ^ (f1 >> FinShiftB);
            return f2 + (f2 << FinShiftC);
        end
    endfunction

endpackage

FILE: sv/one_at_a_time_string_hash.sv
// One-at-a-time string hash: the block takes one byte of a string per beat on the input
// channel, with is_last marking the final beat, and returns one finalized 32-bit hash per
// string. It accepts a new beat in every cycle as long as the output side keeps up; the
// rate is set by the running-hash register, whose add, shift-add and xor-shift update
// is computed combinationally. The mixed hash of a finished string passes through the
// finalization stage register and then the output register, with the finalization applied
// on the way into the output register. A stalled output holds the result and, once the
// finalization stage is also full, holds off further input. Configuration writes are
// always accepted and take effect from the next beat on.
module one_at_a_time_string_hash
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [oaat_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  logic [oaat_pkg::CfgDataWidth-1:0]   cfg_data,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [oaat_pkg::ByteWidth-1:0]      text_byte,
    input  logic                                byte_present,
    input  logic                                is_last,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [oaat_pkg::HashWidth-1:0]      hash_value
);

    logic [oaat_pkg::ShiftWidth-1:0] mix_shift_reg;
    logic                            sign_ext_reg;
    logic [oaat_pkg::HashWidth-1:0]  running_hash_reg;
    logic [oaat_pkg::HashWidth-1:0]  running_hash_next;
    logic [oaat_pkg::HashWidth-1:0]  fin_hash_reg;
    logic                            fin_valid_reg;
    logic [oaat_pkg::HashWidth-1:0]  out_hash_reg;
    logic                            out_valid_reg;
    logic                            in_fire;
    logic                            fin_advance;
    logic                            out_free;

    // Configuration writes never stall.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_shift_reg <= oaat_pkg::MixShiftReset;
            sign_ext_reg  <= oaat_pkg::SignExtReset;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                oaat_pkg::RegMixShift: mix_shift_reg <= cfg_data;
                oaat_pkg::RegSignExt:  sign_ext_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline flow: the output register frees up when empty or taken,
    // and the finalization stage moves on into it.
    assign out_free    = !out_valid_reg || out_ready;
    assign fin_advance = fin_valid_reg && out_free;
    assign in_ready    = !fin_valid_reg || out_free;
    assign in_fire     = in_valid && in_ready;

    // Per-byte mix of the running hash.
    always_comb
    begin
        if (byte_present)
        begin
            running_hash_next = oaat_pkg::mix_byte(running_hash_reg, text_byte,
                                                   mix_shift_reg, sign_ext_reg);
        end
        else
        begin
            running_hash_next = running_hash_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_hash_reg <= '0;
        end
        else if (in_fire)
        begin
            running_hash_reg <= is_last ? '0 : running_hash_next;
        end
    end

    // Finalization stage holds the mixed hash of a completed string.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            fin_valid_reg <= is_last;
        end
        else if (fin_advance)
        begin
            fin_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && is_last)
        begin
            fin_hash_reg <= running_hash_next;
        end
    end

    // Output register with the finalized hash.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_advance)
        begin
            out_hash_reg <= oaat_pkg::finalize(fin_hash_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = out_hash_reg;

    // A string end clears the running hash for the next string.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_last) |=> (running_hash_reg == '0))
        else $error("running hash not cleared after string end");

    // A string end always loads the finalization stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_last) |=> fin_valid_reg)
        else $error("finalization stage not loaded on string end");

    // A beat without a byte and without an end leaves the hash alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !byte_present && !is_last) |=> $stable(running_hash_reg))
        else $error("running hash changed on an empty beat");

    // Input is held off while both result stages are full and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fin_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted with a full, stalled pipeline");

    // A write to the mix shift register lands on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_index == oaat_pkg::RegMixShift)
            |=> (mix_shift_reg == $past(cfg_data)))
        else $error("mix shift write lost");

endmodule

FILE: bench/one_at_a_time_string_hash_tb.sv
module one_at_a_time_string_hash_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import oaat_pkg::*;

    // Index outside the register map; writes to it must change nothing.
    localparam logic [CfgIdxWidth-1:0] RegUnmapped = 8'hFF;

    // Cycles of silence that end the run, and settling time after the last hash.
    localparam int QuietLimit  = 5000;
    localparam int DrainCycles = 4;
    localparam int NumRows     = 26;
    localparam int NumPhases   = 6;
    localparam int PhaseBeats  = 234;
    localparam int LongHold    = 300;

    typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_e;

    typedef struct packed {
        row_kind_e                 kind;
        logic [CfgIdxWidth-1:0]    reg_index;
        logic [CfgDataWidth-1:0]   reg_data;
        logic [ByteWidth-1:0]      text;
        logic                      present;
        logic                      last;
        logic                      known;
        logic [HashWidth-1:0]      known_hash;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CfgIdxWidth-1:0]     cfg_index;
    logic [CfgDataWidth-1:0]    cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic [ByteWidth-1:0]       text_byte;
    logic                       byte_present;
    logic                       is_last;
    logic                       out_valid;
    logic                       out_ready;
    logic [HashWidth-1:0]       hash_value;

    // Predictor state: running hash of the open string and register copies.
    logic [HashWidth-1:0]       string_hash_acc;
    logic [ShiftWidth-1:0]      mix_shift_cfg;
    logic                       sign_ext_cfg;

    logic [HashWidth-1:0]       pending_hashes [$];
    logic [HashWidth-1:0]       oldest_hash;
    int                         mismatch_count = 0;
    int                         beats_sent = 0;
    int                         quiet_cycles = 0;
    int                         send_gap_pct = 0;
    int                         stall_pct = 0;
    int                         hold_request = 0;

    // Columns: kind, register index, register data, byte, present, last, known, hash.
    stim_row_t directed_rows [NumRows] = '{
        // Empty string right after reset hashes to zero.
        '{ROW_BEAT,  RegUnmapped, 5'd0,  8'h00, 1'b0, 1'b1, 1'b1, 32'h0000_0000},
        // Idle beat: nothing happens.
        '{ROW_BEAT,  RegUnmapped, 5'd0,  8'h5A, 1'b0, 1'b0, 1'b0, 32'h0},
        // A lone zero byte leaves the hash at zero.
        '{ROW_BEAT,  RegUnmapped, 5'd0,  8'h00, 1'b1, 1'b1, 1'b1, 32'h0000_0000},
        '{ROW_BEAT,  RegUnmapped, 5'd0,  8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
        '{ROW_BEAT,  RegUnmapped, 5'd0,  8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
        '{ROW_BEAT,  RegUnmapped, 5'd0,  8'h63, 1'b1, 1'b1, 1'b0, 32'h0},
        // Top byte, sign extended, with the end on the same beat.
        '{ROW_BEAT,  RegUnmapped, 5'd0,  8'hFF, 1'b1, 1'b1, 1'b0, 32'h0},
        // Idle beat inside a string, then a bare end marker.
        '{ROW_BEAT,  RegUnmapped, 5'd0,  8'h80, 1'b1, 1'b0, 1'b0, 32'h0},
        '{ROW_BEAT,  RegUnmapped, 5'd0,  8'h3C, 1'b0, 1'b0, 1'b0, 32'h0},
        '{ROW_BEAT,  RegUnmapped, 5'd0,  8'h7F, 1'b1, 1'b0, 1'b0, 32'h0},
        '{ROW_BEAT,  RegUnmapped, 5'd0,  8'h00, 1'b0, 1'b1, 1'b0, 32'h0},
        // Unsigned bytes.
        '{ROW_WRITE, RegSignExt,  5'd0,  8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
        '{ROW_BEAT,  RegUnmapped, 5'd0,  8'hFF, 1'b1, 1'b1, 1'b0, 32'h0},
        // Zero mix shift makes the shift-add step double the hash.
        '{ROW_WRITE, RegMixShift, 5'd0,  8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
        '{ROW_BEAT,  RegUnmapped, 5'd0,  8'h01, 1'b1, 1'b0, 1'b0, 32'h0},
        '{ROW_BEAT,  RegUnmapped, 5'd0,  8'hFE, 1'b1, 1'b1, 1'b0, 32'h0},
        // Largest mix shift.
        '{ROW_WRITE, RegMixShift, 5'd31, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
        '{ROW_BEAT,  RegUnmapped, 5'd0,  8'hAA, 1'b1, 1'b0, 1'b0, 32'h0},
        '{ROW_BEAT,  RegUnmapped, 5'd0,  8'h55, 1'b1, 1'b1, 1'b0, 32'h0},
        // Register write in the middle of a string.
        '{ROW_BEAT,  RegUnmapped, 5'd0,  8'h12, 1'b1, 1'b0, 1'b0, 32'h0},
        '{ROW_WRITE, RegMixShift, 5'd10, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
        '{ROW_BEAT,  RegUnmapped, 5'd0,  8'h34, 1'b1, 1'b1, 1'b0, 32'h0},
        // Write to an unmapped index is dropped.
        '{ROW_WRITE, RegUnmapped, 5'd31, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
        '{ROW_BEAT,  RegUnmapped, 5'd0,  8'h80, 1'b1, 1'b1, 1'b0, 32'h0},
        '{ROW_WRITE, RegSignExt,  5'd1,  8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
        '{ROW_BEAT,  RegUnmapped, 5'd0,  8'h00, 1'b1, 1'b1, 1'b1, 32'h0000_0000}
    };

    one_at_a_time_string_hash dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .text_byte    (text_byte),
        .byte_present (byte_present),
        .is_last      (is_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hash_value   (hash_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Folds one accepted beat into the predicted state; returns the finished
    // hash when the beat closes the string.
    function automatic logic [HashWidth-1:0] hash_beat(
        input logic [ByteWidth-1:0] b,
        input logic                 present,
        input logic                 last
    );
        logic [HashWidth-1:0] h;
        h = string_hash_acc;
        if (present)
        begin
            h = h + {{(HashWidth-ByteWidth){sign_ext_cfg & b[ByteWidth-1]}}, b};
            h = h + (h << mix_shift_cfg);
            h = h ^ (h >> XorShift);
        end
        if (last)
        begin
            h = h + (h << FinShiftA);
            h = h ^ (h >> FinShiftB);
            h = h + (h << FinShiftC);
            string_hash_acc = '0;
        end
        else
        begin
            string_hash_acc = h;
        end
        return h;
    endfunction

    // Offers one beat after an optional random gap and waits for it to be taken.
    task automatic send_beat(
        input logic [ByteWidth-1:0] b,
        input logic                 present,
        input logic                 last,
        input logic                 known,
        input logic [HashWidth-1:0] known_hash
    );
        logic [HashWidth-1:0] folded;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        text_byte    <= b;
        byte_present <= present;
        is_last      <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        folded = hash_beat(b, present, last);
        if (last)
            pending_hashes.push_back(known ? known_hash : folded);
        if (present || last)
            beats_sent++;
    endtask

    // Drops the input and waits until every hash is out and the pipe is quiet.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_hashes.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_reg(
        input logic [CfgIdxWidth-1:0]  idx,
        input logic [CfgDataWidth-1:0] data
    );
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == RegMixShift)
            mix_shift_cfg = data[ShiftWidth-1:0];
        else if (idx == RegSignExt)
            sign_ext_cfg = data[0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One random string: mostly short, some long, bytes biased toward the edges.
    task automatic send_string();
        int unsigned          len;
        int unsigned          i;
        logic [ByteWidth-1:0] b;
        logic                 merge_end;
        len = ($urandom_range(3) == 0) ? $urandom_range(40, 9) : $urandom_range(8);
        merge_end = (len != 0) && ($urandom_range(1) == 1);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(9) == 0)
                send_beat(ByteWidth'($urandom_range(255)), 1'b0, 1'b0, 1'b0, '0);
            case ($urandom_range(9))
                0: b = 8'h00;
                1: b = 8'hFF;
                2: b = 8'h80;
                3: b = 8'h7F;
                default: b = ByteWidth'($urandom_range(255));
            endcase
            send_beat(b, 1'b1, merge_end && (i == len - 1), 1'b0, '0);
        end
        if (!merge_end)
            send_beat(ByteWidth'($urandom_range(255)), 1'b0, 1'b1, 1'b0, '0);
    endtask

    // Stimulus: reset, directed table, then phases of random strings.
    initial
    begin
        int          target;
        int          mid_point;
        logic [4:0]  mix_pick;
        logic        sext_pick;

        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        text_byte    = '0;
        byte_present = 1'b0;
        is_last      = 1'b0;
        string_hash_acc = '0;
        mix_shift_cfg   = MixShiftReset;
        sign_ext_cfg    = SignExtReset;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NumRows; r++)
        begin
            if (directed_rows[r].kind == ROW_WRITE)
            begin
                drain_results();
                write_reg(directed_rows[r].reg_index, directed_rows[r].reg_data);
            end
            else
            begin
                send_beat(directed_rows[r].text, directed_rows[r].present,
                          directed_rows[r].last, directed_rows[r].known,
                          directed_rows[r].known_hash);
            end
        end

        for (int p = 0; p < NumPhases; p++)
        begin
            drain_results();
            mix_pick  = 5'($urandom_range(31));
            sext_pick = 1'($urandom_range(1));
            case (p)
                0:
                begin
                    send_gap_pct = 0;  stall_pct = 0;  mix_pick = 5'd10; sext_pick = 1'b1;
                end
                1:
                begin
                    send_gap_pct = 63; stall_pct = 0;  mix_pick = 5'd0;  sext_pick = 1'b0;
                end
                2:
                begin
                    send_gap_pct = 0;  stall_pct = 63; mix_pick = 5'd31; sext_pick = 1'b1;
                end
                3:
                begin
                    send_gap_pct = 8;  stall_pct = 8;
                end
                4:
                begin
                    send_gap_pct = 63; stall_pct = 63; mix_pick = 5'd0;  sext_pick = 1'b1;
                end
                default:
                begin
                    send_gap_pct = 0;  stall_pct = 0;
                end
            endcase
            write_reg(RegMixShift, mix_pick);
            write_reg(RegSignExt, {4'd0, sext_pick});

            // Long output stall while the input keeps coming, so the block backs up.
            if (p == 0 || p == NumPhases - 1)
                hold_request = LongHold;

            target    = beats_sent + PhaseBeats;
            mid_point = beats_sent + PhaseBeats / 2;
            while (beats_sent < target)
            begin
                send_string();
                // In phase 3 the sender waits once, mid-phase, for every outstanding hash.
                if (p == 3 && beats_sent >= mid_point && mid_point != 0)
                begin
                    drain_results();
                    mid_point = 0;
                end
            end
        end

        drain_results();
        if (mismatch_count == 0 && pending_hashes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Output side: random stalls, plus a long hold-off counted here.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Each hash beat is matched against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_hashes.size() == 0)
            begin
                $error("hash_value: no hash expected, got %08h", hash_value);
                mismatch_count++;
            end
            else
            begin
                oldest_hash = pending_hashes.pop_front();
                if (hash_value !== oldest_hash)
                begin
                    $error("hash_value: expected %08h, got %08h", oldest_hash, hash_value);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run if no channel moves a beat for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QuietLimit)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

FILE: sim.f
sv/oaat_pkg.sv
sv/one_at_a_time_string_hash.sv
bench/one_at_a_time_string_hash_tb.sv
